>>> src/pcbe_pkg.sv
// Shared types and constants for the probe cluster bitrate estimator.
// No dependencies; imported by every module of the block.
`default_nettype none
package pcbe_pkg;

  localparam int CLUSTER_ENTRIES_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_AGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = 1'd1;
  localparam logic [15:0] AGE_RESET = 16'd1000;
  localparam logic [15:0] INTERVAL_RESET = 16'd1000;

  // ceil(2^28 / 5): exact floor(v / 5) for v below 2^26
  localparam int RECIP5_SHIFT = 28;
  localparam logic [25:0] RECIP5 = 26'd53687092;

  localparam int DIV_W = 44;
  localparam int DIVISOR_W = 16;
  localparam int RATE_W = 37;

  typedef enum logic [2:0] {
    STAT_ESTIMATE   = 3'd0,
    STAT_TOO_LITTLE = 3'd1,
    STAT_BAD_IVAL   = 3'd2,
    STAT_RATIO_HIGH = 3'd3,
    STAT_TABLE_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic [30:0] cluster_key;
    logic [31:0] send_time_ms;
    logic [31:0] recv_time_ms;
    logic [15:0] packet_bytes;
    logic [7:0]  min_probe_count;
    logic [23:0] min_byte_count;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [RATE_W-1:0]  bitrate_bps;
  } out_item_t;

  typedef struct packed {
    logic [30:0] cluster_key;
    logic [31:0] send_time_ms;
    logic [31:0] recv_time_ms;
    logic [15:0] packet_bytes;
    logic [7:0]  probe_floor;
    logic [23:0] byte_floor;
  } job_t;

  typedef struct packed {
    logic [30:0] cluster;
    logic [31:0] first_sent;
    logic [31:0] last_sent;
    logic [15:0] last_sent_bytes;
    logic [31:0] first_received;
    logic [15:0] first_received_bytes;
    logic [31:0] last_received;
    logic [23:0] byte_total;
    logic [7:0]  probe_total;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPDATE,
    S_CHECK,
    S_DIV_SEND,
    S_DIV_RECV,
    S_RATIO,
    S_DIV_SCALE,
    S_EMIT
  } eng_state_t;

endpackage
`default_nettype wire

>>> src/pcbe_front.sv
// Input side: takes feedback transactions, derives the 80% probe and byte
// thresholds and holds jobs in a short queue. Depends on pcbe_pkg.
`default_nettype none
module pcbe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pcbe_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_stall,
  output pcbe_pkg::job_t        job
);
  import pcbe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             push, pop;
  logic [35:0]      probe_prod;
  logic [51:0]      byte_prod;
  job_t             new_job;

  assign probe_prod = 36'({in_data.min_probe_count, 2'b00}) * 36'(RECIP5);
  assign byte_prod  = 52'({in_data.min_byte_count, 2'b00}) * 52'(RECIP5);

  always_comb begin
    new_job.cluster_key  = in_data.cluster_key;
    new_job.send_time_ms = in_data.send_time_ms;
    new_job.recv_time_ms = in_data.recv_time_ms;
    new_job.packet_bytes = in_data.packet_bytes;
    new_job.probe_floor  = probe_prod[RECIP5_SHIFT +: 8];
    new_job.byte_floor   = byte_prod[RECIP5_SHIFT +: 24];
  end

  assign in_stall  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != '0);
  assign pop       = job_valid && !job_stall;
  assign job       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> src/pcbe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pcbe_pkg.
`default_nettype none
module pcbe_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pcbe_pkg::div_req_t req,
  output pcbe_pkg::div_rsp_t      rsp
);
  import pcbe_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]     dvd;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [CNT_W-1:0]     steps;
  logic                 done;
  logic [DIVISOR_W:0]   rem_sh;
  logic                 ge;

  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (steps != '0) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= ge ? DIVISOR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      steps <= CNT_W'(DIV_W);
      done  <= 1'b0;
    end else begin
      done <= (steps == CNT_W'(1));
      if (steps != '0) begin
        steps <= steps - 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule
`default_nettype wire

>>> src/pcbe_engine.sv
// Back end: ages and looks up the cluster table, updates the entry and
// derives the estimate with the shared divider. Depends on pcbe_pkg, pcbe_div.
`default_nettype none
module pcbe_engine #(
  parameter int CLUSTER_ENTRIES = pcbe_pkg::CLUSTER_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pcbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           job_valid,
  output logic                                job_stall,
  input  wire pcbe_pkg::job_t                 job,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pcbe_pkg::out_item_t                 out_data
);
  import pcbe_pkg::*;

  localparam int IDX_W = (CLUSTER_ENTRIES > 1) ? $clog2(CLUSTER_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CLUSTER_ENTRIES + 1);

  eng_state_t state, state_next;

  entry_t               mem [CLUSTER_ENTRIES];
  entry_t               rd_q, upd;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [CLUSTER_ENTRIES-1:0] entry_valid;

  logic [15:0] age_lim, ival_lim;
  job_t        item;

  logic [CNT_W-1:0] cnt;
  logic             chk_pend;
  logic [IDX_W-1:0] chk_idx;
  logic             found, free_found, is_new;
  logic [IDX_W-1:0] slot, free_slot;
  logic             scan_done, aged, live;

  logic [23:0] bt;
  logic [7:0]  pt;
  logic [15:0] lsb, frb;
  logic [31:0] siv, riv;
  logic [24:0] bt_sum;

  logic [RATE_W-1:0] send_bps, recv_bps;
  logic [23:0]       send_span, recv_span;
  logic              too_little, bad_ival, ratio_high, scale_down;
  logic [RATE_W-1:0] rate_min;

  logic [39:0] scale_num;
  logic [47:0] sc_num, sc_num_next;
  logic [2:0]  sc_rem, sc_rem_next;
  logic [1:0]  sc_step;
  logic [18:0] sc_v, sc_back;
  logic [44:0] sc_prod;
  logic [15:0] sc_digit;

  status_t           res_status;
  logic [RATE_W-1:0] res_rate;
  logic              load_out;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pcbe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= upd;
    end
    rd_q <= mem[rd_addr];
  end

  assign scan_done = (cnt == CNT_W'(CLUSTER_ENTRIES)) && !chk_pend;
  assign aged = ({1'b0, rd_q.last_received} + 33'(age_lim)) < {1'b0, item.recv_time_ms};
  assign live = entry_valid[chk_idx] && !aged;

  always_comb begin
    bt_sum = {1'b0, rd_q.byte_total} + 25'(item.packet_bytes);
    upd = rd_q;
    if (is_new) begin
      upd.cluster              = item.cluster_key;
      upd.first_sent           = item.send_time_ms;
      upd.last_sent            = item.send_time_ms;
      upd.last_sent_bytes      = item.packet_bytes;
      upd.first_received       = item.recv_time_ms;
      upd.first_received_bytes = item.packet_bytes;
      upd.last_received        = item.recv_time_ms;
      upd.byte_total           = 24'(item.packet_bytes);
      upd.probe_total          = 8'd1;
    end else begin
      if (item.send_time_ms < rd_q.first_sent) begin
        upd.first_sent = item.send_time_ms;
      end
      if (item.send_time_ms > rd_q.last_sent) begin
        upd.last_sent       = item.send_time_ms;
        upd.last_sent_bytes = item.packet_bytes;
      end
      if (item.recv_time_ms < rd_q.first_received) begin
        upd.first_received       = item.recv_time_ms;
        upd.first_received_bytes = item.packet_bytes;
      end
      if (item.recv_time_ms > rd_q.last_received) begin
        upd.last_received = item.recv_time_ms;
      end
      upd.byte_total = bt_sum[24] ? '1 : bt_sum[23:0];
      if (rd_q.probe_total != '1) begin
        upd.probe_total = rd_q.probe_total + 8'd1;
      end
    end
  end

  always_comb begin
    too_little = (pt < item.probe_floor) || (bt < item.byte_floor);
    bad_ival   = (siv == '0) || (siv > 32'(ival_lim)) ||
                 (riv == '0) || (riv > 32'(ival_lim));
    send_span  = (bt > 24'(lsb)) ? bt - 24'(lsb) : '0;
    recv_span  = (bt > 24'(frb)) ? bt - 24'(frb) : '0;
    ratio_high = {1'b0, recv_bps} > {send_bps, 1'b0};
    scale_down = (({4'b0, recv_bps} << 3) + ({4'b0, recv_bps} << 1)) <
                 (({4'b0, send_bps} << 3) + {4'b0, send_bps});
    rate_min   = (send_bps < recv_bps) ? send_bps : recv_bps;
  end

  // recv_bps is a multiple of 8, so 95 * recv_bps / 100 = 38 * (recv_bps / 8) / 5;
  // divided by 5 one 16-bit digit per cycle
  always_comb begin
    scale_num   = (40'(recv_bps[RATE_W-1:3]) << 5) + (40'(recv_bps[RATE_W-1:3]) << 2) +
                  (40'(recv_bps[RATE_W-1:3]) << 1);
    sc_v        = {sc_rem, sc_num[47:32]};
    sc_prod     = 45'(sc_v) * 45'(RECIP5);
    sc_digit    = sc_prod[RECIP5_SHIFT +: 16];
    sc_back     = 19'({sc_digit, 2'b00}) + 19'(sc_digit);
    sc_rem_next = 3'(sc_v - sc_back);
    sc_num_next = {sc_num[31:0], sc_digit};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (job_valid) state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (found) begin
            state_next = S_READ;
          end else if (free_found) begin
            state_next = S_UPDATE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_READ:      state_next = S_UPDATE;
      S_UPDATE:    state_next = S_CHECK;
      S_CHECK:     state_next = (too_little || bad_ival) ? S_EMIT : S_DIV_SEND;
      S_DIV_SEND:  if (div_rsp.done) state_next = S_DIV_RECV;
      S_DIV_RECV:  if (div_rsp.done) state_next = S_RATIO;
      S_RATIO:     state_next = (!ratio_high && scale_down) ? S_DIV_SCALE : S_EMIT;
      S_DIV_SCALE: if (sc_step == 2'd2) state_next = S_EMIT;
      S_EMIT:      if (load_out) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    job_stall        = 1'b1;
    rd_addr          = slot;
    wr_en            = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {10'b0, 34'(send_span) * 34'd1000};
    div_req.divisor  = siv[DIVISOR_W-1:0];
    unique case (state)
      S_IDLE:   job_stall = 1'b0;
      S_SCAN:   rd_addr = cnt[IDX_W-1:0];
      S_UPDATE: wr_en = 1'b1;
      S_CHECK:  div_req.start = !(too_little || bad_ival);
      S_DIV_SEND: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {10'b0, 34'(recv_span) * 34'd1000};
        div_req.divisor  = riv[DIVISOR_W-1:0];
      end
      S_EMIT:   load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      age_lim     <= AGE_RESET;
      ival_lim    <= INTERVAL_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_CLUSTER_AGE) begin
          age_lim <= cfg_data;
        end else if (cfg_index == REG_PROBE_INTERVAL) begin
          ival_lim <= cfg_data;
        end
      end
      if (state == S_SCAN && chk_pend && entry_valid[chk_idx] && aged) begin
        entry_valid[chk_idx] <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[slot] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        item       <= job;
        cnt        <= '0;
        chk_pend   <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      S_SCAN: begin
        chk_pend <= (cnt != CNT_W'(CLUSTER_ENTRIES));
        chk_idx  <= cnt[IDX_W-1:0];
        if (cnt != CNT_W'(CLUSTER_ENTRIES)) begin
          cnt <= cnt + 1'b1;
        end
        if (chk_pend) begin
          if (live && !found && rd_q.cluster == item.cluster_key) begin
            found <= 1'b1;
            slot  <= chk_idx;
          end
          if (!live && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= chk_idx;
          end
        end
        if (scan_done) begin
          is_new <= !found;
          if (!found) begin
            slot <= free_slot;
          end
          res_status <= STAT_TABLE_FULL;
          res_rate   <= '0;
        end
      end
      S_UPDATE: begin
        bt  <= upd.byte_total;
        pt  <= upd.probe_total;
        lsb <= upd.last_sent_bytes;
        frb <= upd.first_received_bytes;
        siv <= upd.last_sent - upd.first_sent;
        riv <= upd.last_received - upd.first_received;
      end
      S_CHECK: begin
        res_status <= too_little ? STAT_TOO_LITTLE : STAT_BAD_IVAL;
        res_rate   <= '0;
      end
      S_DIV_SEND: if (div_rsp.done) send_bps <= {div_rsp.quotient[33:0], 3'b000};
      S_DIV_RECV: if (div_rsp.done) recv_bps <= {div_rsp.quotient[33:0], 3'b000};
      S_RATIO: begin
        res_status <= ratio_high ? STAT_RATIO_HIGH : STAT_ESTIMATE;
        res_rate   <= ratio_high ? '0 : rate_min;
        sc_num     <= {8'b0, scale_num};
        sc_rem     <= '0;
        sc_step    <= '0;
      end
      S_DIV_SCALE: begin
        sc_num  <= sc_num_next;
        sc_rem  <= sc_rem_next;
        sc_step <= sc_step + 2'd1;
        if (sc_step == 2'd2) begin
          res_rate <= sc_num_next[RATE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.status      <= res_status;
      out_data.bitrate_bps <= res_rate;
    end
  end

endmodule
`default_nettype wire

>>> src/probe_cluster_bitrate_estimator.sv
// Probe cluster bitrate estimator, top level.
// Depends on pcbe_pkg, pcbe_front, pcbe_engine.
//
// in_data carries one probe feedback transaction, out_data one result
// (status and bitrate in bit/s). Both channels move a transaction on a
// clock edge with valid high and stall low. The cfg port writes register 0
// (cluster age limit, ms) or 1 (interval limit, ms) on any edge with
// cfg_we high; write only while the block is idle.
// Input transactions enter a two-deep queue, so in_stall rises only when
// two are waiting behind the one in progress.
// Each transaction scans the whole table, one entry per cycle through the
// single memory read port. A full table then goes straight to the result;
// with too little data or a bad interval the result follows the entry
// update; an estimate further needs two divisions on the shared bit-serial
// divider, and a scaled-down receive rate adds a divide-by-5 pass.
// Transactions are processed one at a time.
// Reset empties the queue and the table and loads both limits with 1000.
// A stalled result holds in the output register; the engine finishes the
// next transaction and waits until that register frees.
`default_nettype none
module probe_cluster_bitrate_estimator #(
  parameter int CLUSTER_ENTRIES = pcbe_pkg::CLUSTER_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pcbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pcbe_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pcbe_pkg::out_item_t                 out_data
);
  import pcbe_pkg::*;

  logic job_valid, job_stall;
  job_t job;

  pcbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job)
  );

  pcbe_engine #(
    .CLUSTER_ENTRIES (CLUSTER_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> tb/sv/probe_cluster_bitrate_estimator_tb.sv
// Testbench for probe_cluster_bitrate_estimator: random and directed probe feedback
// checked against an in-bench cluster table predictor. Depends on pcbe_pkg and the RTL.
`default_nettype none
module probe_cluster_bitrate_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcbe_pkg::*;

  localparam int ENTRIES = CLUSTER_ENTRIES_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  probe_cluster_bitrate_estimator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [15:0] age_limit = AGE_RESET;
  logic [15:0] ival_limit = INTERVAL_RESET;
  logic ent_used [ENTRIES];
  entry_t ent [ENTRIES];
  out_item_t pending_results[$];

  int errors = 0;
  int sent = 0;
  int checked = 0;
  int est_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  logic [31:0] now_ms = 32'd5000;

  function automatic out_item_t predict_bitrate(in_item_t it);
    int slot, free_slot;
    logic [63:0] s_iv, r_iv, s_sz, r_sz, s_bps, r_bps, rate, bsum;
    out_item_t r;
    slot = -1;
    free_slot = -1;
    r = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (ent_used[i] && ({32'd0, ent[i].last_received} + age_limit) < {32'd0, it.recv_time_ms})
        ent_used[i] = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_used[i]) begin
        if (slot < 0 && ent[i].cluster == it.cluster_key) slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        r.status = STAT_TABLE_FULL;
        return r;
      end
      slot = free_slot;
      ent_used[slot] = 1'b1;
      ent[slot].cluster = it.cluster_key;
      ent[slot].first_sent = it.send_time_ms;
      ent[slot].last_sent = it.send_time_ms;
      ent[slot].last_sent_bytes = it.packet_bytes;
      ent[slot].first_received = it.recv_time_ms;
      ent[slot].first_received_bytes = it.packet_bytes;
      ent[slot].last_received = it.recv_time_ms;
      ent[slot].byte_total = {8'd0, it.packet_bytes};
      ent[slot].probe_total = 8'd1;
    end else begin
      if (it.send_time_ms < ent[slot].first_sent) ent[slot].first_sent = it.send_time_ms;
      if (it.send_time_ms > ent[slot].last_sent) begin
        ent[slot].last_sent = it.send_time_ms;
        ent[slot].last_sent_bytes = it.packet_bytes;
      end
      if (it.recv_time_ms < ent[slot].first_received) begin
        ent[slot].first_received = it.recv_time_ms;
        ent[slot].first_received_bytes = it.packet_bytes;
      end
      if (it.recv_time_ms > ent[slot].last_received) ent[slot].last_received = it.recv_time_ms;
      bsum = ent[slot].byte_total + it.packet_bytes;
      ent[slot].byte_total = (bsum > 64'hFFFFFF) ? 24'hFFFFFF : bsum[23:0];
      if (ent[slot].probe_total != 8'hFF) ent[slot].probe_total++;
    end
    if (ent[slot].probe_total < (10'(it.min_probe_count) * 10'd4) / 10'd5 ||
        ent[slot].byte_total < (64'(it.min_byte_count) * 4) / 5) begin
      r.status = STAT_TOO_LITTLE;
      return r;
    end
    s_iv = 64'(ent[slot].last_sent - ent[slot].first_sent);
    r_iv = 64'(ent[slot].last_received - ent[slot].first_received);
    if (s_iv == 0 || s_iv > ival_limit || r_iv == 0 || r_iv > ival_limit) begin
      r.status = STAT_BAD_IVAL;
      return r;
    end
    s_sz = (ent[slot].byte_total > ent[slot].last_sent_bytes) ?
           64'(ent[slot].byte_total - ent[slot].last_sent_bytes) : 64'd0;
    r_sz = (ent[slot].byte_total > ent[slot].first_received_bytes) ?
           64'(ent[slot].byte_total - ent[slot].first_received_bytes) : 64'd0;
    s_bps = 8 * ((s_sz * 1000) / s_iv);
    r_bps = 8 * ((r_sz * 1000) / r_iv);
    if (r_bps > 2 * s_bps) begin
      r.status = STAT_RATIO_HIGH;
      return r;
    end
    rate = (s_bps < r_bps) ? s_bps : r_bps;
    if (10 * r_bps < 9 * s_bps) rate = (r_bps * 95) / 100;
    r.status = STAT_ESTIMATE;
    r.bitrate_bps = rate[RATE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          out_item_t w;
          w = pending_results.pop_front();
          if (out_data.status !== w.status) report_mismatch("status", out_data.status, w.status);
          if (out_data.bitrate_bps !== w.bitrate_bps)
            report_mismatch("bitrate_bps", out_data.bitrate_bps, w.bitrate_bps);
          if (w.status == STAT_ESTIMATE) est_count++;
        end
        checked++;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL probe_cluster_bitrate_estimator");
        $finish;
      end
    end
  end

  task automatic send_probe(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_bitrate(it));
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CLUSTER_AGE) age_limit = val;
    else ival_limit = val;
    @(posedge clk);
  endtask

  function automatic in_item_t make_probe(logic [30:0] cid, logic [31:0] st, logic [31:0] rt,
                                          logic [15:0] sz, logic [7:0] mp, logic [23:0] mb);
    in_item_t it;
    it.cluster_key = cid;
    it.send_time_ms = st;
    it.recv_time_ms = rt;
    it.packet_bytes = sz;
    it.min_probe_count = mp;
    it.min_byte_count = mb;
    return it;
  endfunction

  task automatic test_directed();
    send_probe(make_probe(31'h7FFFFFFF, 32'd100, 32'd100, 16'hFFFF, 8'd1, 24'd1));
    send_probe(make_probe(31'h7FFFFFFF, 32'd150, 32'd160, 16'd1200, 8'd1, 24'd1));
    send_probe(make_probe(31'h7FFFFFFF, 32'd200, 32'd300, 16'd1200, 8'd1, 24'd1));
    send_probe(make_probe(31'd0, 32'd400, 32'd400, 16'd0, 8'd255, 24'hFFFFFF));
    send_probe(make_probe(31'd0, 32'd410, 32'd420, 16'd0, 8'd1, 24'd1));
    send_probe(make_probe(31'd1, 32'd500, 32'd500, 16'd1000, 8'd1, 24'd1));
    send_probe(make_probe(31'd1, 32'd501, 32'd502, 16'd0, 8'd1, 24'd1));
    send_probe(make_probe(31'd1, 32'd450, 32'd2000, 16'd500, 8'd1, 24'd1));
    for (int i = 0; i < 17; i++)
      send_probe(make_probe(31'd100 + i, 32'd2000, 32'd2100, 16'd50, 8'd5, 24'd100));
    send_probe(make_probe(31'd5, 32'hFFFFFFF0, 32'hFFFFFFFF, 16'd10, 8'd1, 24'd1));
    wait_idle();
  endtask

  task automatic test_clusters(int n, int pkt_per);
    logic [30:0] cid;
    logic [31:0] st, rt;
    int k;
    k = 0;
    while (k < n) begin
      now_ms = now_ms + $urandom_range(3000);
      cid = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(40));
      st = now_ms;
      rt = now_ms + $urandom_range(200);
      for (int p = 0; p < pkt_per && k < n; p++, k++) begin
        if ($urandom_range(9) == 0)
          send_probe(make_probe(31'($urandom), $urandom, $urandom, 16'($urandom),
                                8'($urandom), 24'($urandom)));
        else
          send_probe(make_probe(cid, st + $urandom_range(2) - 1,
                                rt + $urandom_range(3) - 1, 16'($urandom_range(1500)),
                                8'($urandom_range(pkt_per + 2, 1)),
                                24'($urandom_range(pkt_per * 800, 1))));
        st = st + $urandom_range(40);
        rt = rt + $urandom_range(40);
        if ($urandom_range(40) == 0) cid = cid ^ 31'h40000000;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles <= 800;
    for (int i = 0; i < 8; i++)
      send_probe(make_probe(31'd7, 32'd90000 + i * 5, 32'd90000 + i * 7, 16'd600, 8'd2, 24'd1));
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) ent_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 13;
    recv_idle_pct = 49;
    test_directed();
    write_reg(REG_CLUSTER_AGE, 16'd1);
    write_reg(REG_PROBE_INTERVAL, 16'd65535);
    test_clusters(500, 8);
    wait_idle();
    write_reg(REG_CLUSTER_AGE, 16'd65535);
    write_reg(REG_PROBE_INTERVAL, 16'd1);
    send_idle_pct = 49;
    recv_idle_pct = 13;
    test_clusters(400, 6);
    wait_idle();
    write_reg(REG_CLUSTER_AGE, 16'd0);
    write_reg(REG_PROBE_INTERVAL, 16'd0);
    test_clusters(100, 4);
    wait_idle();
    write_reg(REG_CLUSTER_AGE, 16'd2500);
    write_reg(REG_PROBE_INTERVAL, 16'd400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_clusters(900, 10);
    wait_idle();
    $display("sent %0d probe transactions, checked %0d results, %0d estimates",
             sent, checked, est_count);
    if (errors == 0) begin
      $display("PASS probe_cluster_bitrate_estimator");
    end else begin
      $display("FAIL probe_cluster_bitrate_estimator");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
src/pcbe_pkg.sv
src/pcbe_front.sv
src/pcbe_div.sv
src/pcbe_engine.sv
src/probe_cluster_bitrate_estimator.sv
tb/sv/probe_cluster_bitrate_estimator_tb.sv
